// File: src/rrpt_pkg.sv
// rrpt_pkg: command, status and sequencer state types for the pick table
`default_nettype none
package rrpt_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_NEXT   = 2'd2,
    CMD_RANDOM = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_MOD,
    ST_PICK,
    ST_RESULT
  } state_t;

  localparam int unsigned SpotWidth  = 16;
  localparam int unsigned SkipWidth  = 8;
  localparam int unsigned RandWidth  = 16;
  localparam int unsigned CountWidth = 6;

endpackage
`default_nettype wire

// File: src/rrpt_ram.sv
// rrpt_ram: generic single write, single read ram with registered read data
`default_nettype none
module rrpt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: src/rrpt_mod.sv
// rrpt_mod: bit-serial restoring remainder unit, one numerator bit per cycle
`default_nettype none
module rrpt_mod #(
  parameter int unsigned NUM_W = 16,
  parameter int unsigned DEN_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [DEN_W-1:0] rem
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num_sh;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   den_ext;

  assign trial   = {rem, num_sh[NUM_W-1]};
  assign den_ext = {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      num_sh <= num;
      cnt    <= CNT_W'(NUM_W);
    end else if (busy) begin
      if (trial >= den_ext) begin
        rem <= DEN_W'(trial - den_ext);
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      cnt    <= cnt - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// File: src/dedup_round_robin_pick_table.sv
// dedup_round_robin_pick_table: ordered unique-id table with round-robin and random pick
//
//  channel | direction | handshake           | fields
//  in      | request   | in_valid / in_stall | command spot_id skip_limit random_value
//  out     | result    | out_valid/out_stall | status picked_id entry_count
//
// one request at a time; add scans the table in ram at one entry a cycle;
// remove scans the same way, then shifts every entry behind the hit down by one place
// next passes through the pick state when it gives an entry; random waits on the remainder unit
// reset clears count, cursor, skip counter and pick flag; ram contents undefined
// a held result in the output register delays only the finish of the following request
`default_nettype none
module dedup_round_robin_pick_table
  import rrpt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            command,
  input  wire logic [SpotWidth-1:0]  spot_id,
  input  wire logic [SkipWidth-1:0]  skip_limit,
  input  wire logic [RandWidth-1:0]  random_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 status,
  output logic [SpotWidth-1:0]       picked_id,
  output logic [CountWidth-1:0]      entry_count
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;

  cmd_t                cmd, cmd_next;
  logic [ID_WIDTH-1:0] id_reg, id_next;
  logic [CW-1:0]       count, count_next;
  logic [AW-1:0]       cursor, cursor_next;
  logic [SkipWidth-1:0] skip, skip_next;
  logic                picked_once, picked_once_next;
  logic [CW-1:0]       scan_idx, scan_next;
  logic [AW-1:0]       cmp_idx, cmp_next;
  logic [AW-1:0]       wr_idx, wr_next;
  logic [AW-1:0]       pos, pos_next;
  logic                rd_pending, rd_pending_next;
  status_t             res_status, res_status_next;
  logic [SpotWidth-1:0] res_picked, res_picked_next;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ID_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [ID_WIDTH-1:0] mem_rdata;

  logic                mod_start;
  logic                mod_done;
  logic [CW-1:0]       mod_rem;

  logic [ID_WIDTH+SpotWidth-1:0] id_ext;
  logic [ID_WIDTH-1:0]           id_in;
  logic [ID_WIDTH+SpotWidth-1:0] pick_ext;
  logic [CW+CountWidth-1:0]      count_ext;

  logic                hit;
  logic                out_free;
  logic [AW-1:0]       at;
  logic [CW-1:0]       at_inc;
  logic [SkipWidth:0]  raised;
  logic [AW-1:0]       cur_adj;

  status_t              out_status;
  logic [SpotWidth-1:0] out_picked;
  logic [CountWidth-1:0] out_count;

  assign id_ext    = {{ID_WIDTH{1'b0}}, spot_id};
  assign id_in     = id_ext[ID_WIDTH-1:0];
  assign pick_ext  = {{SpotWidth{1'b0}}, mem_rdata};
  assign count_ext = {{CountWidth{1'b0}}, count};

  assign hit      = rd_pending && (mem_rdata == id_reg);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  assign at      = (CW'(cursor) < count) ? cursor : '0;
  assign at_inc  = CW'(at) + CW'(1);
  assign raised  = {1'b0, skip} + (SkipWidth+1)'(1);
  assign cur_adj = (cursor > pos) ? (cursor - AW'(1)) : cursor;

  rrpt_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  rrpt_mod #(
    .NUM_W (RandWidth),
    .DEN_W (CW)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .num   (random_value),
    .den   (count),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_comb begin
    state_next       = state;
    cmd_next         = cmd;
    id_next          = id_reg;
    count_next       = count;
    cursor_next      = cursor;
    skip_next        = skip;
    picked_once_next = picked_once;
    scan_next        = scan_idx;
    cmp_next         = cmp_idx;
    wr_next          = wr_idx;
    pos_next         = pos;
    rd_pending_next  = rd_pending;
    res_status_next  = res_status;
    res_picked_next  = res_picked;
    mem_we           = 1'b0;
    mem_waddr        = wr_idx;
    mem_wdata        = mem_rdata;
    mem_raddr        = scan_idx[AW-1:0];
    mod_start        = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_next        = cmd_t'(command);
          id_next         = id_in;
          scan_next       = '0;
          rd_pending_next = 1'b0;
          res_status_next = STATUS_MISS;
          res_picked_next = '0;
          state_next      = ST_RESULT;
          case (cmd_t'(command))
            CMD_ADD, CMD_REMOVE: begin
              state_next = ST_SEARCH;
            end
            CMD_NEXT: begin
              if (count != '0) begin
                if (raised > {1'b0, skip_limit}) begin
                  mem_raddr        = at;
                  skip_next        = '0;
                  picked_once_next = 1'b1;
                  cursor_next      = (at_inc >= count) ? '0 : AW'(at_inc);
                  state_next       = ST_PICK;
                end else begin
                  skip_next = raised[SkipWidth-1:0];
                end
              end
            end
            CMD_RANDOM: begin
              if ((count != '0) && !picked_once) begin
                mod_start        = 1'b1;
                picked_once_next = 1'b1;
                state_next       = ST_MOD;
              end
            end
            default: begin
              state_next = ST_RESULT;
            end
          endcase
        end
      end

      ST_SEARCH: begin
        if (hit) begin
          pos_next        = cmp_idx;
          rd_pending_next = 1'b0;
          if (cmd == CMD_ADD) begin
            res_status_next = STATUS_MISS;
            state_next      = ST_RESULT;
          end else begin
            scan_next  = CW'(cmp_idx) + CW'(1);
            state_next = ST_SHIFT;
          end
        end else if ((scan_idx == count) && !rd_pending) begin
          if (cmd == CMD_ADD) begin
            if (count == CW'(TABLE_DEPTH)) begin
              res_status_next = STATUS_FULL;
            end else begin
              mem_we          = 1'b1;
              mem_waddr       = count[AW-1:0];
              mem_wdata       = id_reg;
              count_next      = count + CW'(1);
              res_status_next = STATUS_OK;
            end
          end else begin
            res_status_next = STATUS_MISS;
          end
          state_next = ST_RESULT;
        end else if (scan_idx < count) begin
          mem_raddr       = scan_idx[AW-1:0];
          rd_pending_next = 1'b1;
          cmp_next        = scan_idx[AW-1:0];
          scan_next       = scan_idx + CW'(1);
        end else begin
          rd_pending_next = 1'b0;
        end
      end

      ST_SHIFT: begin
        if (rd_pending) begin
          mem_we    = 1'b1;
          mem_waddr = wr_idx;
          mem_wdata = mem_rdata;
        end
        if (scan_idx < count) begin
          mem_raddr       = scan_idx[AW-1:0];
          wr_next         = AW'(scan_idx - CW'(1));
          rd_pending_next = 1'b1;
          scan_next       = scan_idx + CW'(1);
        end else begin
          rd_pending_next = 1'b0;
          if (!rd_pending) begin
            count_next      = count - CW'(1);
            cursor_next     = (CW'(cur_adj) >= (count - CW'(1))) ? '0 : cur_adj;
            res_status_next = STATUS_OK;
            state_next      = ST_RESULT;
          end
        end
      end

      ST_MOD: begin
        if (mod_done) begin
          mem_raddr  = AW'(mod_rem);
          state_next = ST_PICK;
        end
      end

      ST_PICK: begin
        res_picked_next = pick_ext[SpotWidth-1:0];
        res_status_next = STATUS_OK;
        state_next      = ST_RESULT;
      end

      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      cursor      <= '0;
      skip        <= '0;
      picked_once <= 1'b0;
      rd_pending  <= 1'b0;
    end else begin
      count       <= count_next;
      cursor      <= cursor_next;
      skip        <= skip_next;
      picked_once <= picked_once_next;
      rd_pending  <= rd_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    id_reg     <= id_next;
    scan_idx   <= scan_next;
    cmp_idx    <= cmp_next;
    wr_idx     <= wr_next;
    pos        <= pos_next;
    res_status <= res_status_next;
    res_picked <= res_picked_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_RESULT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RESULT) && out_free) begin
      out_status <= res_status;
      out_picked <= res_picked;
      out_count  <= count_ext[CountWidth-1:0];
    end
  end

  assign status      = out_status;
  assign picked_id   = out_picked;
  assign entry_count = out_count;

endmodule
`default_nettype wire
